// ===== rtl/core/slc_pkg.sv =====
// Shared types, codes and helpers for the SDP line classifier.
// Used by sdp_line_classifier and slc_checker; depends on nothing else.
`timescale 1ns / 1ps

package slc_pkg;

    localparam int SLC_MAX_MEDIA      = 8;
    localparam int SLC_MAX_BANDWIDTH  = 4;
    localparam int SLC_MAX_ATTRIBUTES = 16;
    localparam int SLC_POSITION_BITS  = 16;

    localparam logic [3:0] KIND_V       = 4'd0;
    localparam logic [3:0] KIND_O       = 4'd1;
    localparam logic [3:0] KIND_S       = 4'd2;
    localparam logic [3:0] KIND_I       = 4'd3;
    localparam logic [3:0] KIND_U       = 4'd4;
    localparam logic [3:0] KIND_E       = 4'd5;
    localparam logic [3:0] KIND_P       = 4'd6;
    localparam logic [3:0] KIND_C       = 4'd7;
    localparam logic [3:0] KIND_B       = 4'd8;
    localparam logic [3:0] KIND_Z       = 4'd9;
    localparam logic [3:0] KIND_K       = 4'd10;
    localparam logic [3:0] KIND_A       = 4'd11;
    localparam logic [3:0] KIND_T       = 4'd12;
    localparam logic [3:0] KIND_R       = 4'd13;
    localparam logic [3:0] KIND_M       = 4'd14;
    localparam logic [3:0] KIND_UNKNOWN = 4'd15;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_EQ = 8'h3D;

    typedef enum logic [2:0] {
        PH_START  = 3'b001,
        PH_LETTER = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [3:0]  line_kind;
        logic [3:0]  section;
        logic [3:0]  slot;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        stored;
        logic        message_end;
        logic [3:0]  media_count;
    } rec_t;

    function automatic logic [3:0] letter_kind(input logic [7:0] b);
        logic [3:0] k;
        case (b)
            8'h76:   k = KIND_V;
            8'h6F:   k = KIND_O;
            8'h73:   k = KIND_S;
            8'h69:   k = KIND_I;
            8'h75:   k = KIND_U;
            8'h65:   k = KIND_E;
            8'h70:   k = KIND_P;
            8'h63:   k = KIND_C;
            8'h62:   k = KIND_B;
            8'h7A:   k = KIND_Z;
            8'h6B:   k = KIND_K;
            8'h61:   k = KIND_A;
            8'h74:   k = KIND_T;
            8'h72:   k = KIND_R;
            8'h6D:   k = KIND_M;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ===== rtl/core/sdp_line_classifier.sv =====
// Top level of the SDP line classifier: input register, line parser, result queue.
// Depends on slc_pkg.
`timescale 1ns / 1ps

// The block takes a session description one byte a word and gives one record for
// each finished line (LF or CRLF; a lone CR is content, and the final byte of a
// message closes its last line). Throughput is one byte per clock while in_stall is low.
// A byte is held in the input register; the parse of that byte, with its few compares
// and counter updates, then writes the record into a two-entry output queue, and the
// record is offered from the head of that queue.
// in_stall rises only when the queue is full and the byte in the input register
// would close a line.
module sdp_line_classifier #(
    parameter int MAX_MEDIA      = slc_pkg::SLC_MAX_MEDIA,
    parameter int MAX_BANDWIDTH  = slc_pkg::SLC_MAX_BANDWIDTH,
    parameter int MAX_ATTRIBUTES = slc_pkg::SLC_MAX_ATTRIBUTES,
    parameter int POSITION_BITS  = slc_pkg::SLC_POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  line_kind,
    output logic [3:0]  section,
    output logic [3:0]  slot,
    output logic [15:0] value_offset,
    output logic [15:0] value_length,
    output logic        stored,
    output logic        message_end,
    output logic [3:0]  media_count
);

    localparam int MW = $clog2(MAX_MEDIA + 1);
    localparam int BW = $clog2(MAX_BANDWIDTH + 1);
    localparam int AW = $clog2(MAX_ATTRIBUTES + 1);
    localparam int PW = POSITION_BITS;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;

    // Parser state.
    logic [PW-1:0]    pos_reg,  pos_next;
    slc_pkg::phase_t  ph_reg,   ph_next;
    logic [3:0]       kind_reg, kind_next;
    logic             pcr_reg,  pcr_next;
    logic             sess_reg, sess_next;
    logic             open_reg, open_next;
    logic [MW-1:0]    mt_reg,   mt_next;
    logic [BW-1:0]    bw_reg,   bw_next;
    logic [AW-1:0]    at_reg,   at_next;
    logic [PW-1:0]    vs_reg,   vs_next;
    logic [15:0]      vb_reg,   vb_next;

    // Output queue.
    logic          occ0_reg, occ1_reg;
    slc_pkg::rec_t q0_reg, q1_reg;

    logic          done;
    logic          s1_go;
    logic          push;
    logic          pop;
    slc_pkg::rec_t rec;

    always_comb
    begin
        logic [PW-1:0]   c_pos;
        slc_pkg::phase_t c_ph;
        logic [3:0]      c_kind;
        logic            c_pcr;
        logic            c_sess;
        logic            c_open;
        logic [MW-1:0]   c_mt;
        logic [BW-1:0]   c_bw;
        logic [AW-1:0]   c_at;
        logic [PW-1:0]   c_vs;
        logic [15:0]     c_vb;
        logic [3:0]      lk;
        logic            feed;
        logic            usable;
        logic [3:0]      r_slot;
        logic            r_stored;

        // A first byte starts from the reset state.
        if (s1_first_reg)
        begin
            c_pos  = '0;
            c_ph   = slc_pkg::PH_START;
            c_kind = slc_pkg::KIND_UNKNOWN;
            c_pcr  = 1'b0;
            c_sess = 1'b1;
            c_open = 1'b0;
            c_mt   = '0;
            c_bw   = '0;
            c_at   = '0;
            c_vs   = '0;
            c_vb   = '0;
        end
        else
        begin
            c_pos  = pos_reg;
            c_ph   = ph_reg;
            c_kind = kind_reg;
            c_pcr  = pcr_reg;
            c_sess = sess_reg;
            c_open = open_reg;
            c_mt   = mt_reg;
            c_bw   = bw_reg;
            c_at   = at_reg;
            c_vs   = vs_reg;
            c_vb   = vb_reg;
        end

        lk        = slc_pkg::letter_kind(s1_byte_reg);
        feed      = 1'b0;
        done      = 1'b0;
        usable    = 1'b0;
        r_slot    = '0;
        r_stored  = 1'b0;
        pos_next  = c_pos + PW'(1);
        ph_next   = c_ph;
        kind_next = c_kind;
        pcr_next  = c_pcr;
        vs_next   = c_vs;
        vb_next   = c_vb;

        case (c_ph)
            slc_pkg::PH_START:
            begin
                vs_next = c_pos;
                vb_next = '0;
                if (lk != slc_pkg::KIND_UNKNOWN)
                begin
                    kind_next = lk;
                    ph_next   = slc_pkg::PH_LETTER;
                end
                else
                begin
                    kind_next = slc_pkg::KIND_UNKNOWN;
                    ph_next   = slc_pkg::PH_VALUE;
                    feed      = 1'b1;
                end
            end
            slc_pkg::PH_LETTER:
            begin
                ph_next = slc_pkg::PH_VALUE;
                if (s1_byte_reg == slc_pkg::CHAR_EQ)
                begin
                    vs_next = c_pos + PW'(1);
                    vb_next = '0;
                end
                else
                begin
                    // The letter was not followed by '=', so the line is unknown.
                    kind_next = slc_pkg::KIND_UNKNOWN;
                    vb_next   = 16'd1;
                    feed      = 1'b1;
                end
            end
            default:
            begin
                feed = 1'b1;
            end
        endcase

        if (feed)
        begin
            if (pcr_next)
            begin
                pcr_next = 1'b0;
                if (s1_byte_reg == slc_pkg::CHAR_LF)
                    done = 1'b1;
                else
                    vb_next = slc_pkg::sat_inc(vb_next);
            end
            if (!done)
            begin
                if (s1_byte_reg == slc_pkg::CHAR_LF)
                    done = 1'b1;
                else if (s1_byte_reg == slc_pkg::CHAR_CR)
                    pcr_next = 1'b1;
                else
                    vb_next = slc_pkg::sat_inc(vb_next);
            end
        end

        // The final byte closes whatever line is still open.
        if (!done && s1_last_reg)
        begin
            if (ph_next == slc_pkg::PH_LETTER)
            begin
                kind_next = slc_pkg::KIND_UNKNOWN;
                vb_next   = 16'd1;
            end
            if (pcr_next)
            begin
                vb_next  = slc_pkg::sat_inc(vb_next);
                pcr_next = 1'b0;
            end
            done = 1'b1;
        end

        sess_next = c_sess;
        open_next = c_open;
        mt_next   = c_mt;
        bw_next   = c_bw;
        at_next   = c_at;

        if (done)
        begin
            if (kind_next == slc_pkg::KIND_M)
            begin
                sess_next = 1'b0;
                if (c_mt < MW'(MAX_MEDIA))
                begin
                    mt_next   = c_mt + MW'(1);
                    open_next = 1'b1;
                    bw_next   = '0;
                    at_next   = '0;
                    r_stored  = 1'b1;
                end
                else
                begin
                    open_next = 1'b0;
                end
            end
            else if (kind_next != slc_pkg::KIND_UNKNOWN)
            begin
                // Media sections keep only i, c, k, b and a lines.
                usable = c_sess || (c_open && (kind_next == slc_pkg::KIND_I ||
                                               kind_next == slc_pkg::KIND_C ||
                                               kind_next == slc_pkg::KIND_K ||
                                               kind_next == slc_pkg::KIND_B ||
                                               kind_next == slc_pkg::KIND_A));
                if (usable)
                begin
                    if (kind_next == slc_pkg::KIND_B)
                    begin
                        if (c_bw < BW'(MAX_BANDWIDTH))
                        begin
                            r_slot   = 4'(c_bw);
                            bw_next  = c_bw + BW'(1);
                            r_stored = 1'b1;
                        end
                    end
                    else if (kind_next == slc_pkg::KIND_A)
                    begin
                        if (c_at < AW'(MAX_ATTRIBUTES))
                        begin
                            r_slot   = 4'(c_at);
                            at_next  = c_at + AW'(1);
                            r_stored = 1'b1;
                        end
                    end
                    else
                    begin
                        r_stored = 1'b1;
                    end
                end
            end
        end

        rec.line_kind    = kind_next;
        rec.section      = (!sess_next && open_next) ? 4'(mt_next) : 4'd0;
        rec.slot         = r_slot;
        rec.value_offset = 16'(vs_next);
        rec.value_length = vb_next;
        rec.stored       = r_stored;
        rec.message_end  = s1_last_reg;
        rec.media_count  = 4'(mt_next);

        if (done)
        begin
            ph_next   = slc_pkg::PH_START;
            kind_next = slc_pkg::KIND_UNKNOWN;
            pcr_next  = 1'b0;
            vb_next   = '0;
            if (s1_last_reg)
            begin
                pos_next  = '0;
                sess_next = 1'b1;
                open_next = 1'b0;
                mt_next   = '0;
                bw_next   = '0;
                at_next   = '0;
                vs_next   = '0;
            end
        end
    end

    // A byte that closes no line never waits on the queue.
    assign s1_go    = !(occ0_reg && occ1_reg) || !done;
    assign in_stall = s1_valid_reg && !s1_go;
    assign push     = s1_valid_reg && s1_go && done;
    assign pop      = occ0_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= '0;
            ph_reg       <= slc_pkg::PH_START;
            kind_reg     <= slc_pkg::KIND_UNKNOWN;
            pcr_reg      <= 1'b0;
            sess_reg     <= 1'b1;
            open_reg     <= 1'b0;
            mt_reg       <= '0;
            bw_reg       <= '0;
            at_reg       <= '0;
            vs_reg       <= '0;
            vb_reg       <= '0;
            occ0_reg     <= 1'b0;
            occ1_reg     <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;

            if (s1_valid_reg && s1_go)
            begin
                pos_reg  <= pos_next;
                ph_reg   <= ph_next;
                kind_reg <= kind_next;
                pcr_reg  <= pcr_next;
                sess_reg <= sess_next;
                open_reg <= open_next;
                mt_reg   <= mt_next;
                bw_reg   <= bw_next;
                at_reg   <= at_next;
                vs_reg   <= vs_next;
                vb_reg   <= vb_next;
            end

            if (!occ0_reg)
                occ0_reg <= push;
            else if (!occ1_reg)
            begin
                if (pop)
                    occ0_reg <= push;
                else
                    occ1_reg <= push;
            end
            else if (pop)
                occ1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end

        if (!occ0_reg || (pop && !occ1_reg))
        begin
            if (push)
                q0_reg <= rec;
        end
        else if (occ1_reg)
        begin
            if (pop)
                q0_reg <= q1_reg;
        end
        else if (push)
            q1_reg <= rec;
    end

    assign out_valid    = occ0_reg;
    assign line_kind    = q0_reg.line_kind;
    assign section      = q0_reg.section;
    assign slot         = q0_reg.slot;
    assign value_offset = q0_reg.value_offset;
    assign value_length = q0_reg.value_length;
    assign stored       = q0_reg.stored;
    assign message_end  = q0_reg.message_end;
    assign media_count  = q0_reg.media_count;

endmodule

// ===== rtl/core/slc_checker.sv =====
// Port-level checks for sdp_line_classifier, attached by the bind at the end.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_checker #(
    parameter int MAX_MEDIA = slc_pkg::SLC_MAX_MEDIA
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  line_kind,
    input logic [3:0]  section,
    input logic [3:0]  slot,
    input logic        stored,
    input logic [3:0]  media_count
);

    // A word offered on the result side stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_unknown_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_kind == slc_pkg::KIND_UNKNOWN |-> !stored)
        else $error("unknown line reported as stored");

    // A stored m line opens the newest section.
    a_media_section: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stored && line_kind == slc_pkg::KIND_M |->
            section == media_count && (MAX_MEDIA > 15 || media_count != 4'd0))
        else $error("stored media line does not open the newest section");

    a_slot_use: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot != 4'd0 |->
            stored && (line_kind == slc_pkg::KIND_B || line_kind == slc_pkg::KIND_A))
        else $error("nonzero slot on a line that holds no slot");

endmodule

bind sdp_line_classifier slc_checker #(
    .MAX_MEDIA(MAX_MEDIA)
) u_slc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_kind   (line_kind),
    .section     (section),
    .slot        (slot),
    .stored      (stored),
    .media_count (media_count)
);
